// ===== hw/rtl/pmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pmrc_pkg
// Shared widths, register indexes and stage payload types.
// ----------------------------------------------------------------------------
package pmrc_pkg;

    localparam int COORD_BITS        = 32;
    localparam int DIFF_W            = COORD_BITS + 1;
    localparam int PROD_W            = 2 * DIFF_W;
    localparam int TAG_W             = 16;
    localparam int MIN_RING_VERTICES = 4;
    localparam int CNT_W             = $clog2(MIN_RING_VERTICES + 1);
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_AW           = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW           = FIFO_AW + 1;
    localparam int S_DATA_W          = ((2 * COORD_BITS + TAG_W + 7) / 8) * 8;
    localparam int M_DATA_W          = ((1 + TAG_W + 7) / 8) * 8;
    localparam int S_USER_W          = 3;
    localparam int CFG_AW            = 1;

    typedef enum logic [CFG_AW-1:0] {
        REG_QUERY_X = 1'b0,
        REG_QUERY_Y = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] vx;
        logic signed [COORD_BITS-1:0] vy;
        logic                         is_hole;
        logic                         ring_mark;
        logic                         part_mark;
        logic                         end_feature;
        logic [TAG_W-1:0]             tag;
    } vtx_t;

    typedef struct packed {
        logic                     ok;
        logic                     d_neg;
        logic signed [DIFF_W-1:0] a;
        logic signed [DIFF_W-1:0] d;
        logic signed [DIFF_W-1:0] c;
        logic signed [DIFF_W-1:0] e;
    } edge_t;

    typedef struct packed {
        logic             is_hole;
        logic             end_ring;
        logic             end_part;
        logic             end_feature;
        logic             ring_full;
        logic [TAG_W-1:0] tag;
    } ctl_t;

    typedef struct packed {
        edge_t e1;
        edge_t e2;
        ctl_t  ctl;
    } stg1_t;

    typedef struct packed {
        logic                     ok;
        logic                     d_neg;
        logic signed [PROD_W-1:0] lhs;
        logic signed [PROD_W-1:0] rhs;
    } prod_t;

    typedef struct packed {
        prod_t p1;
        prod_t p2;
        ctl_t  ctl;
    } stg2_t;

    typedef struct packed {
        logic             hit;
        logic [TAG_W-1:0] tag;
    } res_t;

    function automatic logic signed [DIFF_W-1:0] sub_ext(
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y
    );
        logic signed [DIFF_W-1:0] xe;
        logic signed [DIFF_W-1:0] ye;
        xe = DIFF_W'(x);
        ye = DIFF_W'(y);
        return xe - ye;
    endfunction

endpackage

// ===== hw/rtl/pmrc_front.sv =====
// ----------------------------------------------------------------------------
// pmrc_front
// Ring tracking (first/previous vertex, vertex count) and edge differences.
// ----------------------------------------------------------------------------
module pmrc_front
    import pmrc_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic signed [COORD_BITS-1:0] query_x,
    input  logic signed [COORD_BITS-1:0] query_y,
    input  logic                         in_valid,
    input  vtx_t                         in_vtx,
    output logic                         s1_valid,
    output stg1_t                        s1_data
);

    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic signed [COORD_BITS-1:0] first_x_next, first_y_next;
    logic [CNT_W-1:0]             cnt_inc;
    logic                         end_part, end_ring;
    logic                         v_above, p_above, f_above;
    logic                         valid_reg;
    stg1_t                        data_reg, data_next;

    assign end_part = in_vtx.part_mark | in_vtx.end_feature;
    assign end_ring = in_vtx.ring_mark | end_part;

    assign first_x_next = (cnt_reg == '0) ? in_vtx.vx : first_x_reg;
    assign first_y_next = (cnt_reg == '0) ? in_vtx.vy : first_y_reg;
    assign cnt_inc  = (cnt_reg < CNT_W'(MIN_RING_VERTICES)) ? cnt_reg + 1'b1 : cnt_reg;
    assign cnt_next = end_ring ? '0 : cnt_inc;

    assign v_above = in_vtx.vy > query_y;
    assign p_above = prev_y_reg > query_y;
    assign f_above = first_y_next > query_y;

    always_comb begin
        // edge from this vertex to the previous one
        data_next.e1.ok    = (cnt_reg != '0) && (v_above != p_above);
        data_next.e1.d     = sub_ext(prev_y_reg, in_vtx.vy);
        data_next.e1.d_neg = data_next.e1.d[DIFF_W-1];
        data_next.e1.c     = sub_ext(prev_x_reg, in_vtx.vx);
        data_next.e1.e     = sub_ext(query_y, in_vtx.vy);
        data_next.e1.a     = sub_ext(query_x, in_vtx.vx);
        // closing edge from first vertex to this one
        data_next.e2.ok    = end_ring && (f_above != v_above);
        data_next.e2.d     = sub_ext(in_vtx.vy, first_y_next);
        data_next.e2.d_neg = data_next.e2.d[DIFF_W-1];
        data_next.e2.c     = sub_ext(in_vtx.vx, first_x_next);
        data_next.e2.e     = sub_ext(query_y, first_y_next);
        data_next.e2.a     = sub_ext(query_x, first_x_next);
        data_next.ctl.is_hole     = in_vtx.is_hole;
        data_next.ctl.end_ring    = end_ring;
        data_next.ctl.end_part    = end_part;
        data_next.ctl.end_feature = in_vtx.end_feature;
        data_next.ctl.ring_full   = cnt_inc >= CNT_W'(MIN_RING_VERTICES);
        data_next.ctl.tag         = in_vtx.tag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            cnt_reg     <= '0;
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end else begin
            valid_reg <= in_valid;
            if (in_valid) begin
                cnt_reg     <= cnt_next;
                first_x_reg <= first_x_next;
                first_y_reg <= first_y_next;
                prev_x_reg  <= in_vtx.vx;
                prev_y_reg  <= in_vtx.vy;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            data_reg <= data_next;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

// ===== hw/rtl/pmrc_mult.sv =====
// ----------------------------------------------------------------------------
// pmrc_mult
// Cross products of both edges, registered.
// ----------------------------------------------------------------------------
module pmrc_mult
    import pmrc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s1_valid,
    input  stg1_t s1_data,
    output logic  s2_valid,
    output stg2_t s2_data
);

    logic  valid_reg;
    stg2_t data_reg, data_next;

    always_comb begin
        data_next.p1.ok    = s1_data.e1.ok;
        data_next.p1.d_neg = s1_data.e1.d_neg;
        data_next.p1.lhs   = PROD_W'($signed(s1_data.e1.a) * $signed(s1_data.e1.d));
        data_next.p1.rhs   = PROD_W'($signed(s1_data.e1.c) * $signed(s1_data.e1.e));
        data_next.p2.ok    = s1_data.e2.ok;
        data_next.p2.d_neg = s1_data.e2.d_neg;
        data_next.p2.lhs   = PROD_W'($signed(s1_data.e2.a) * $signed(s1_data.e2.d));
        data_next.p2.rhs   = PROD_W'($signed(s1_data.e2.c) * $signed(s1_data.e2.e));
        data_next.ctl      = s1_data.ctl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid) begin
            data_reg <= data_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2_data  = data_reg;

endmodule

// ===== hw/rtl/pmrc_accum.sv =====
// ----------------------------------------------------------------------------
// pmrc_accum
// Crossing compare, ring parity and part/feature membership accumulation.
// ----------------------------------------------------------------------------
module pmrc_accum
    import pmrc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s2_valid,
    input  stg2_t s2_data,
    output logic  res_push,
    output res_t  res_data
);

    logic parity_reg, ext_reg, hole_reg, feat_reg;
    logic parity_next, ext_next, hole_next, feat_next;
    logic x1, x2, par_n, ring_in, ext_n, hole_n, feat_n;
    logic signed [PROD_W-1:0] l1, r1, l2, r2;

    assign l1 = s2_data.p1.lhs;
    assign r1 = s2_data.p1.rhs;
    assign l2 = s2_data.p2.lhs;
    assign r2 = s2_data.p2.rhs;

    // negative edge height flips the sense of the compare
    assign x1 = s2_data.p1.ok && (s2_data.p1.d_neg ? (l1 > r1) : (l1 < r1));
    assign x2 = s2_data.p2.ok && (s2_data.p2.d_neg ? (l2 > r2) : (l2 < r2));

    always_comb begin
        par_n   = parity_reg ^ x1 ^ x2;
        ring_in = par_n & s2_data.ctl.ring_full;
        ext_n   = ext_reg;
        hole_n  = hole_reg;
        if (s2_data.ctl.end_ring) begin
            if (s2_data.ctl.is_hole) begin
                hole_n = hole_reg | ring_in;
            end else begin
                ext_n = ext_reg | ring_in;
            end
        end
        feat_n = feat_reg;
        if (s2_data.ctl.end_part) begin
            feat_n = feat_reg | (ext_n & ~hole_n);
        end

        parity_next = s2_data.ctl.end_ring    ? 1'b0 : par_n;
        ext_next    = s2_data.ctl.end_part    ? 1'b0 : ext_n;
        hole_next   = s2_data.ctl.end_part    ? 1'b0 : hole_n;
        feat_next   = s2_data.ctl.end_feature ? 1'b0 : feat_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 1'b0;
            ext_reg    <= 1'b0;
            hole_reg   <= 1'b0;
            feat_reg   <= 1'b0;
        end else if (s2_valid) begin
            parity_reg <= parity_next;
            ext_reg    <= ext_next;
            hole_reg   <= hole_next;
            feat_reg   <= feat_next;
        end
    end

    assign res_push     = s2_valid & s2_data.ctl.end_feature;
    assign res_data.hit = feat_n;
    assign res_data.tag = s2_data.ctl.tag;

endmodule

// ===== hw/rtl/pmrc_fifo.sv =====
// ----------------------------------------------------------------------------
// pmrc_fifo
// Small result queue decoupling the pipeline from the output beat.
// ----------------------------------------------------------------------------
module pmrc_fifo
    import pmrc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  res_t               push_data,
    input  logic               pop,
    output logic               not_empty,
    output res_t               head,
    output logic [FIFO_CW-1:0] count
);

    res_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] cnt_reg, cnt_next;
    logic               do_pop;

    assign do_pop   = pop & (cnt_reg != '0);
    assign cnt_next = cnt_reg + FIFO_CW'(push) - FIFO_CW'(do_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = cnt_reg != '0;
    assign head      = mem[rd_ptr_reg];
    assign count     = cnt_reg;

endmodule

// ===== hw/rtl/polygon_membership_ray_cast_top.sv =====
// ----------------------------------------------------------------------------
// polygon_membership_ray_cast_top
// Even-odd point-in-polygon test of a query point against streamed rings.
// Throughput: one vertex beat per cycle; the input stalls only when the
//   four-entry result queue plus feature ends in flight would overflow.
// Pipeline: a closing vertex passes the registered difference stage and
//   product stage, then compare/accumulate queues the feature result.
// Reset: synchronous, active low; clears ring, part and feature state,
//   query registers and the result queue. No clearing pass.
// ----------------------------------------------------------------------------
module polygon_membership_ray_cast_top
    import pmrc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_wr_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    // vertex_x, vertex_y, feature_tag
    input  logic [S_DATA_W-1:0] s_tdata,
    // ring_is_hole, last_of_ring, last_of_part
    input  logic [S_USER_W-1:0] s_tuser,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // inside_res, result_tag, zero pad
    output logic [M_DATA_W-1:0] m_tdata
);

    logic signed [COORD_BITS-1:0] query_x_reg, query_y_reg;
    logic                         in_beat;
    vtx_t                         in_vtx;
    logic                         s1_valid, s2_valid;
    stg1_t                        s1_data;
    stg2_t                        s2_data;
    logic                         res_push;
    res_t                         res_data, head;
    logic [FIFO_CW-1:0]           fifo_cnt, pending;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_x_reg <= '0;
            query_y_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_QUERY_X: query_x_reg <= cfg_wr_data;
                REG_QUERY_Y: query_y_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign pending = fifo_cnt
                   + FIFO_CW'(s1_valid & s1_data.ctl.end_feature)
                   + FIFO_CW'(s2_valid & s2_data.ctl.end_feature);
    assign s_tready = pending < FIFO_CW'(FIFO_DEPTH);
    assign in_beat  = s_tvalid & s_tready;

    assign in_vtx.vx          = s_tdata[COORD_BITS-1:0];
    assign in_vtx.vy          = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_vtx.tag         = s_tdata[2*COORD_BITS+TAG_W-1:2*COORD_BITS];
    assign in_vtx.is_hole     = s_tuser[0];
    assign in_vtx.ring_mark   = s_tuser[1];
    assign in_vtx.part_mark   = s_tuser[2];
    assign in_vtx.end_feature = s_tlast;

    pmrc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .query_x  (query_x_reg),
        .query_y  (query_y_reg),
        .in_valid (in_beat),
        .in_vtx   (in_vtx),
        .s1_valid (s1_valid),
        .s1_data  (s1_data)
    );

    pmrc_mult u_mult (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s2_data  (s2_data)
    );

    pmrc_accum u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s2_valid (s2_valid),
        .s2_data  (s2_data),
        .res_push (res_push),
        .res_data (res_data)
    );

    pmrc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res_data),
        .pop       (m_tready),
        .not_empty (m_tvalid),
        .head      (head),
        .count     (fifo_cnt)
    );

    assign m_tdata = M_DATA_W'({head.tag, head.hit});

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pending <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue over-committed");

    a_close_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_beat && s_tlast) |-> ##2 res_push)
        else $error("closing vertex produced no result");

    a_result_has_close: assert property (@(posedge aclk) disable iff (!aresetn)
        res_push |-> $past(in_beat && s_tlast, 2))
        else $error("result without closing vertex");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for polygon_membership_ray_cast_top. Vertex beats are
// driven on the input stream with random gaps. A local ray-cast model with
// exact wide arithmetic predicts the verdict of each feature. Every result
// beat is compared with the oldest prediction. A directed table comes first,
// then random multipart polygons in several query-point phases.
// ----------------------------------------------------------------------------
module tb_top;
    import pmrc_pkg::*;

    localparam int          STALL_LIMIT   = 5000;
    localparam int          HOLD_CYCLES   = 250;
    localparam int          HOLD_AT_BEAT  = 350;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          PHASE_BEATS   = 175;
    localparam int          NUM_PHASES    = 6;
    localparam int          DIR_ROWS      = 24;
    localparam logic [31:0] C_MIN         = 32'h8000_0000;
    localparam logic [31:0] C_MAX         = 32'h7fff_ffff;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [71:0]           wide_t;

    typedef struct packed {
        coord_t           x;
        coord_t           y;
        logic             hole;
        logic             ring;
        logic             part;
        logic             feat;
        logic [TAG_W-1:0] tag;
    } vertex_t;

    typedef struct packed {
        coord_t           x;
        coord_t           y;
        logic             hole;
        logic             ring;
        logic             part;
        logic             feat;
        logic [TAG_W-1:0] tag;
        logic             fixed;
        logic             fixed_inside;
    } dir_row_t;

    typedef struct packed {
        logic             hit;
        logic [TAG_W-1:0] tag;
    } verdict_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_AW-1:0]     cfg_addr;
    logic [COORD_BITS-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    polygon_membership_ray_cast_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // model state
    coord_t   qry_x = '0;
    coord_t   qry_y = '0;
    coord_t   ring_first_x = '0;
    coord_t   ring_first_y = '0;
    coord_t   ring_prev_x = '0;
    coord_t   ring_prev_y = '0;
    int       ring_count = 0;
    bit       ring_parity = 0;
    bit       part_outer_in = 0;
    bit       part_hole_in = 0;
    bit       feature_in = 0;

    verdict_t pending_verdicts[$];
    int       mismatch_count = 0;
    int       beats_sent = 0;
    int       stall_cycles = 0;
    bit       calm = 0;
    bit       hold_done = 0;
    int       hold_left = 0;

    // query (0,0) after reset
    dir_row_t dir_table[DIR_ROWS] = '{
        // triangle around the point: too few vertices
        '{-10, -10, 1'b0, 1'b0, 1'b0, 1'b0, 16'h1234, 1'b0, 1'b0},
        '{ 10, -10, 1'b0, 1'b0, 1'b0, 1'b0, 16'h1234, 1'b0, 1'b0},
        '{  0,  10, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0},
        // square with horizontal edges, closed by tlast alone
        '{-10, -10, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ 10, -10, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ 10,  10, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{-10,  10, 1'b0, 1'b0, 1'b0, 1'b1, 16'hffff, 1'b1, 1'b1},
        // full-range square, repeated closing vertex
        '{C_MIN, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff, 1'b0, 1'b0},
        '{C_MAX, C_MIN, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff, 1'b0, 1'b0},
        '{C_MAX, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff, 1'b0, 1'b0},
        '{C_MIN, C_MAX, 1'b0, 1'b0, 1'b0, 1'b0, 16'hffff, 1'b0, 1'b0},
        '{C_MIN, C_MIN, 1'b0, 1'b1, 1'b1, 1'b1, 16'h0001, 1'b1, 1'b1},
        // exterior with a hole over the point
        '{-100, -100, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ 100, -100, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ 100,  100, 1'b0, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{-100,  100, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{  -5,   -5, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{   5,   -5, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{   5,    5, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{  -5,    5, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0002, 1'b1, 1'b0},
        // part made of a hole only
        '{-100, -100, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ 100, -100, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{ 100,  100, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
        '{-100,  100, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0003, 1'b1, 1'b0}
    };

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // even-odd test of one edge against the ray toward +x, no division
    function automatic bit edge_hits_ray(input coord_t ax, input coord_t ay,
                                         input coord_t bx, input coord_t by);
        wide_t wax, way, wbx, wby, wqx, wqy;
        wide_t dy, dx, ey, ex;
        if ((ay > qry_y) == (by > qry_y))
            return 1'b0;
        wax = ax;
        way = ay;
        wbx = bx;
        wby = by;
        wqx = qry_x;
        wqy = qry_y;
        dy = wby - way;
        dx = wbx - wax;
        ey = wqy - way;
        ex = wqx - wax;
        if (dy < 0) begin
            dy = -dy;
            dx = -dx;
        end
        return (ex * dy) < (dx * ey);
    endfunction

    function automatic bit predict_membership(input vertex_t v, output verdict_t res);
        bit end_part, end_ring, ring_in;
        end_part = v.part | v.feat;
        end_ring = v.ring | end_part;
        res = '0;
        if (ring_count == 0) begin
            ring_first_x = v.x;
            ring_first_y = v.y;
        end else if (edge_hits_ray(v.x, v.y, ring_prev_x, ring_prev_y)) begin
            ring_parity = ~ring_parity;
        end
        ring_prev_x = v.x;
        ring_prev_y = v.y;
        if (ring_count < MIN_RING_VERTICES)
            ring_count++;
        if (end_ring) begin
            if (edge_hits_ray(ring_first_x, ring_first_y, v.x, v.y))
                ring_parity = ~ring_parity;
            ring_in = ring_parity && (ring_count >= MIN_RING_VERTICES);
            if (v.hole)
                part_hole_in = part_hole_in | ring_in;
            else
                part_outer_in = part_outer_in | ring_in;
            ring_count = 0;
            ring_parity = 0;
        end
        if (end_part) begin
            if (part_outer_in && !part_hole_in)
                feature_in = 1;
            part_outer_in = 0;
            part_hole_in = 0;
        end
        if (v.feat) begin
            res.hit = feature_in;
            res.tag = v.tag;
            feature_in = 0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_vertex(input vertex_t v, input bit fixed, input logic fixed_inside);
        verdict_t res;
        while (!calm && $urandom_range(0, 99) < 33) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {v.tag, v.y, v.x};
        s_tuser  <= {v.part, v.ring, v.hole};
        s_tlast  <= v.feat;
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
        if (predict_membership(v, res)) begin
            if (fixed)
                res.hit = fixed_inside;
            pending_verdicts.insert(pending_verdicts.size(), res);
        end
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_query(input coord_t qx, input coord_t qy);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_QUERY_X;
        cfg_wr_data <= qx;
        @(negedge aclk);
        cfg_addr    <= REG_QUERY_Y;
        cfg_wr_data <= qy;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        qry_x = qx;
        qry_y = qy;
    endtask

    // one feature: star-shaped rings around points near the query
    task automatic emit_feature();
        vertex_t beats[$];
        vertex_t v, fv;
        int      n_parts, n_rings, ext_at, n_vtx, quad, last;
        longint  cx, cy, hx, hy, rad, hrad, px, py;
        bit      noisy, h;
        noisy = ($urandom_range(0, 11) == 0);
        n_parts = $urandom_range(1, 3);
        rad = longint'(1) << $urandom_range(2, 30);
        cx = longint'(qry_x) + longint'($urandom_range(0, 32'(2 * rad))) - rad;
        cy = longint'(qry_y) + longint'($urandom_range(0, 32'(2 * rad))) - rad;
        for (int p = 0; p < n_parts; p++) begin
            n_rings = $urandom_range(1, 3);
            if ($urandom_range(0, 9) == 0)
                ext_at = -1;
            else if ($urandom_range(0, 3) == 0)
                ext_at = $urandom_range(0, n_rings - 1);
            else
                ext_at = 0;
            for (int r = 0; r < n_rings; r++) begin
                h = (r != ext_at) && ($urandom_range(0, 7) != 0);
                hrad = h ? (rad >> $urandom_range(1, 4)) : rad;
                if (hrad < 2)
                    hrad = 2;
                hx = cx + longint'($urandom_range(0, 32'(hrad))) - hrad / 2;
                hy = cy + longint'($urandom_range(0, 32'(hrad))) - hrad / 2;
                n_vtx = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                    : $urandom_range(4, 7);
                for (int k = 0; k < n_vtx; k++) begin
                    quad = (k * 4) / n_vtx;
                    px = longint'($urandom_range(1, 32'(hrad)));
                    py = longint'($urandom_range(1, 32'(hrad)));
                    px = (quad == 0 || quad == 3) ? hx + px : hx - px;
                    py = (quad < 2) ? hy + py : hy - py;
                    case ($urandom_range(0, 19))
                        0: py = qry_y;
                        1: px = qry_x;
                        2: if (k > 0) py = beats[beats.size() - 1].y;
                        default: ;
                    endcase
                    v.x = coord_t'(px);
                    v.y = coord_t'(py);
                    if (noisy || $urandom_range(0, 15) == 0) begin
                        v.x = coord_t'($urandom);
                        v.y = coord_t'($urandom);
                    end
                    v.hole = ($urandom_range(0, 4) == 0) ? ~h : h;
                    v.ring = noisy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 39) == 0);
                    v.part = noisy && ($urandom_range(0, 7) == 0);
                    v.feat = 1'b0;
                    v.tag  = TAG_W'($urandom);
                    if (k == 0)
                        fv = v;
                    beats.insert(beats.size(), v);
                end
                if (n_vtx >= 3 && $urandom_range(0, 5) == 0)
                    beats.insert(beats.size(), fv);
                last = beats.size() - 1;
                beats[last].hole = h;
                beats[last].ring = 1'b1;
            end
            last = beats.size() - 1;
            beats[last].part = 1'b1;
            if ($urandom_range(0, 2) == 0)
                beats[last].ring = 1'b0;
        end
        last = beats.size() - 1;
        beats[last].feat = 1'b1;
        if ($urandom_range(0, 2) == 0) begin
            beats[last].part = 1'b0;
            beats[last].ring = 1'b0;
        end
        foreach (beats[i])
            send_vertex(beats[i], 1'b0, 1'b0);
    endtask

    // result side ready pattern, with one long hold-off
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && beats_sent >= HOLD_AT_BEAT) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                flag_mismatch("unexpected result beat", 32'(m_tdata), 32'd0);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[0] !== want.hit)
                    flag_mismatch("inside_res", 32'(m_tdata[0]), 32'(want.hit));
                if (m_tdata[TAG_W:1] !== want.tag)
                    flag_mismatch("result_tag", 32'(m_tdata[TAG_W:1]), 32'(want.tag));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin : stimulus
        vertex_t v;
        int      phase_start;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= REG_QUERY_X;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        s_tlast     <= 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_table[i]) begin
            v.x    = dir_table[i].x;
            v.y    = dir_table[i].y;
            v.hole = dir_table[i].hole;
            v.ring = dir_table[i].ring;
            v.part = dir_table[i].part;
            v.feat = dir_table[i].feat;
            v.tag  = dir_table[i].tag;
            send_vertex(v, dir_table[i].fixed, dir_table[i].fixed_inside);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            calm = (phase == 2);
            case (phase)
                0: set_query(coord_t'($urandom), coord_t'($urandom));
                1: set_query(C_MAX, C_MAX);
                2: set_query(coord_t'(int'($urandom_range(0, 2000)) - 1000),
                             coord_t'(int'($urandom_range(0, 2000)) - 1000));
                3: set_query(C_MIN, C_MIN);
                4: set_query(coord_t'($urandom), coord_t'($urandom));
                default: set_query(C_MIN, C_MAX);
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS)
                emit_feature();
        end
        calm = 0;

        wait_drained();
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
